### rtl/cfes_pkg.sv
`timescale 1ns / 1ps
// shared constants, calendar tables and divider request/response types
// for the calendar fields to epoch seconds converter; no dependencies
package cfes_pkg;

  localparam int YEAR_SPAN_LIMIT = 5000;
  localparam int DAY_FIELD_LIMIT = 1000;
  localparam int YEAR_BASE       = 1900;
  localparam int EPOCH_YEAR      = 1970;
  localparam int CYCLE_DAYS      = 146097;  // days in 400 gregorian years
  localparam int SECS_PER_DAY    = 86400;

  // epoch year split into whole 400 year cycles and the year within the cycle
  localparam int EPOCH_CYCLE_Q = EPOCH_YEAR / 400;
  localparam int EPOCH_CYCLE_R = EPOCH_YEAR % 400;

  localparam logic signed [16:0] DAY_LIM     = 17'(DAY_FIELD_LIMIT);
  localparam logic signed [15:0] YEAR_LIM    = 16'(YEAR_SPAN_LIMIT);
  localparam logic signed [15:0] EPOCH_SHIFT = 16'(EPOCH_YEAR - YEAR_BASE);

  // shared floor divider
  localparam int DIV_NUM_W  = 19;
  localparam int DIV_MAG_W  = DIV_NUM_W;
  localparam int DIV_DEN_W  = 9;
  // ceil(2**27 / d) gives the exact quotient for magnitudes up to 2**18, d < 512
  localparam int RCP_SHIFT  = 27;
  localparam int RCP_W      = 25;
  localparam int DIV_PROD_W = DIV_MAG_W + RCP_W;
  localparam int DIV_QA_W   = DIV_PROD_W - RCP_SHIFT;
  localparam int DIV_QD_W   = DIV_QA_W + DIV_DEN_W;
  localparam int DIV_QUO_W  = DIV_QA_W + 1;

  localparam logic [RCP_W-1:0] RCP_60  = RCP_W'((2**RCP_SHIFT + 59) / 60);
  localparam logic [RCP_W-1:0] RCP_24  = RCP_W'((2**RCP_SHIFT + 23) / 24);
  localparam logic [RCP_W-1:0] RCP_12  = RCP_W'((2**RCP_SHIFT + 11) / 12);
  localparam logic [RCP_W-1:0] RCP_400 = RCP_W'((2**RCP_SHIFT + 399) / 400);
  localparam logic [RCP_W-1:0] RCP_7   = RCP_W'((2**RCP_SHIFT + 6) / 7);

  typedef struct packed {
    logic                        start;
    logic signed [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0]        den;
    logic [RCP_W-1:0]            rcp;
  } div_req_t;

  typedef struct packed {
    logic                        done;
    logic signed [DIV_QUO_W-1:0] quo;
    logic [DIV_DEN_W-1:0]        rem;
  } div_rsp_t;

  function automatic logic [4:0] month_len(input logic [3:0] mon);
    logic [4:0] n;
    unique case (mon)
      4'd1:                      n = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   n = 5'd30;
      default:                   n = 5'd31;
    endcase
    return n;
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
    return month_len(mon) + 5'((mon == 4'd1) && leap);
  endfunction

  function automatic logic [8:0] days_before(input logic [3:0] mon, input logic leap);
    logic [8:0] n;
    unique case (mon)
      4'd0:    n = 9'd0;
      4'd1:    n = 9'd31;
      4'd2:    n = 9'd59;
      4'd3:    n = 9'd90;
      4'd4:    n = 9'd120;
      4'd5:    n = 9'd151;
      4'd6:    n = 9'd181;
      4'd7:    n = 9'd212;
      4'd8:    n = 9'd243;
      4'd9:    n = 9'd273;
      4'd10:   n = 9'd304;
      default: n = 9'd334;
    endcase
    return n + 9'((mon > 4'd1) && leap);
  endfunction

  // leap rule on the year taken modulo 400
  function automatic logic leap400(input logic [8:0] r);
    return (r[1:0] == 2'b00) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
  endfunction

  // days from the start of a 400 year cycle to the start of year r within it
  function automatic logic [17:0] cycle_days(input logic [8:0] r);
    logic [2:0] c;
    if (r == 9'd0)        c = 3'd0;
    else if (r <= 9'd100) c = 3'd1;
    else if (r <= 9'd200) c = 3'd2;
    else if (r <= 9'd300) c = 3'd3;
    else                  c = 3'd4;
    return 18'(r) * 18'd365 + 18'(({1'b0, r} + 10'd3) >> 2) - 18'(c) + 18'(r != 9'd0);
  endfunction

  localparam logic [17:0] EPOCH_CYCLE_DAYS = cycle_days(9'(EPOCH_CYCLE_R));

endpackage

### rtl/cfes_fdiv.sv
`timescale 1ns / 1ps
// shared floor divider (uses cfes_pkg): signed value times the scaled reciprocal
// of a small constant divisor, quotient rounded toward minus infinity; steps mul, rem, fix
module cfes_fdiv (
  input  logic              clk,
  input  logic              rst_n,
  input  cfes_pkg::div_req_t req,
  output cfes_pkg::div_rsp_t rsp
);
  import cfes_pkg::*;

  localparam logic [1:0] STEP_MUL = 2'd0;
  localparam logic [1:0] STEP_REM = 2'd1;
  localparam logic [1:0] STEP_FIX = 2'd2;

  logic                        busy_r;
  logic                        done_r;
  logic                        neg_r;
  logic [DIV_MAG_W-1:0]        mag_r;
  logic [DIV_DEN_W-1:0]        den_r;
  logic [RCP_W-1:0]            rcp_r;
  logic [1:0]                  step_r;
  logic [DIV_PROD_W-1:0]       prod_r;
  logic [DIV_QA_W-1:0]         qa_r;
  logic [DIV_DEN_W-1:0]        rem_r;
  logic signed [DIV_QUO_W-1:0] quo_r;
  logic [DIV_DEN_W-1:0]        rr_r;

  logic [DIV_MAG_W-1:0]        mag_in;
  logic [DIV_PROD_W-1:0]       prod;
  logic [DIV_QA_W-1:0]         qa_nxt;
  logic [DIV_QD_W-1:0]         qd;
  logic [DIV_MAG_W-1:0]        rem_full;
  logic [DIV_DEN_W-1:0]        rem_nxt;
  logic signed [DIV_QUO_W-1:0] quo_nxt;
  logic [DIV_DEN_W-1:0]        rr_nxt;

  always_comb begin
    mag_in = req.num[DIV_NUM_W-1] ? DIV_MAG_W'(-req.num) : DIV_MAG_W'(req.num);

    prod     = DIV_PROD_W'(mag_r) * DIV_PROD_W'(rcp_r);
    qa_nxt   = prod_r[DIV_PROD_W-1 -: DIV_QA_W];
    qd       = DIV_QD_W'(qa_nxt) * DIV_QD_W'(den_r);
    rem_full = mag_r - DIV_MAG_W'(qd);
    rem_nxt  = DIV_DEN_W'(rem_full);

    // negative dividend: divide the magnitude, then round down
    if (neg_r && (rem_r != '0)) begin
      quo_nxt = -($signed({1'b0, qa_r}) + DIV_QUO_W'(1));
      rr_nxt  = den_r - rem_r;
    end else if (neg_r) begin
      quo_nxt = -$signed({1'b0, qa_r});
      rr_nxt  = '0;
    end else begin
      quo_nxt = $signed({1'b0, qa_r});
      rr_nxt  = rem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        if (step_r == STEP_FIX) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (req.start) begin
        busy_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      step_r <= step_r + 2'd1;
      if (step_r == STEP_MUL) begin
        prod_r <= prod;
      end
      if (step_r == STEP_REM) begin
        qa_r  <= qa_nxt;
        rem_r <= rem_nxt;
      end
      if (step_r == STEP_FIX) begin
        quo_r <= quo_nxt;
        rr_r  <= rr_nxt;
      end
    end else if (req.start) begin
      neg_r  <= req.num[DIV_NUM_W-1];
      mag_r  <= mag_in;
      den_r  <= req.den;
      rcp_r  <= req.rcp;
      step_r <= STEP_MUL;
    end
  end

  always_comb begin
    rsp.done = done_r;
    rsp.quo  = quo_r;
    rsp.rem  = rr_r;
  end

endmodule

### rtl/calendar_fields_to_epoch_seconds.sv
`timescale 1ns / 1ps
// broken-down utc time to seconds since 1970 with field normalization
// depends on cfes_pkg and the shared floor divider cfes_fdiv
//
// An item is taken when start is high and busy is low; busy then stays high
// until the result, which appears on the out_ ports with out_strobe, high for
// a single cycle, and busy is already low in that cycle. The receiver cannot stall.
// Every out of range second, minute, hour or month field takes a pass through
// the shared reciprocal divider (a field in range only gets its range check);
// the year modulo 400 and the weekday take a pass each in the same divider;
// rolling the day of month steps once per month crossed (up to about 34)
// plus a final step; two multiply steps and the final sum follow, and the result
// shows in the cycle after the sum. An item whose day of month or year lies
// outside the limits ends early with out_valid_res low and all other result
// fields zero.
module calendar_fields_to_epoch_seconds (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_second,
  input  logic signed [15:0] in_minute,
  input  logic signed [15:0] in_hour,
  input  logic signed [15:0] in_day_of_month,
  input  logic signed [12:0] in_month,
  input  logic signed [13:0] in_year,
  output logic               out_strobe,
  output logic               out_valid_res,
  output logic signed [38:0] out_epoch_seconds,
  output logic [5:0]         out_corrections,
  output logic [5:0]         out_second,
  output logic [5:0]         out_minute,
  output logic [4:0]         out_hour,
  output logic [4:0]         out_day_of_month,
  output logic [3:0]         out_month,
  output logic signed [14:0] out_year,
  output logic [2:0]         out_weekday,
  output logic [8:0]         out_day_of_year
);
  import cfes_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_SEC  = 13'b0000000000010,
    S_MIN  = 13'b0000000000100,
    S_HOUR = 13'b0000000001000,
    S_MON  = 13'b0000000010000,
    S_CHK  = 13'b0000000100000,
    S_Y400 = 13'b0000001000000,
    S_ROLL = 13'b0000010000000,
    S_MUL1 = 13'b0000100000000,
    S_DAY  = 13'b0001000000000,
    S_WDAY = 13'b0010000000000,
    S_MUL2 = 13'b0100000000000,
    S_SUM  = 13'b1000000000000
  } state_t;

  state_t              state_r, state_nxt;
  logic                pend_r, pend_nxt;
  logic signed [15:0]  sec_r, sec_nxt;
  logic signed [16:0]  min_r, min_nxt;
  logic signed [16:0]  hour_r, hour_nxt;
  logic signed [16:0]  mday_r, mday_nxt;
  logic signed [12:0]  mon_r, mon_nxt;
  logic signed [14:0]  year_r, year_nxt;
  logic [5:0]          cnt_r, cnt_nxt;
  logic [8:0]          r400_r, r400_nxt;
  logic signed [6:0]   q400_r, q400_nxt;
  logic [8:0]          yday_r, yday_nxt;
  logic signed [22:0]  day_r, day_nxt;
  logic [2:0]          wday_r, wday_nxt;
  logic signed [39:0]  acc_r, acc_nxt;

  logic                strobe_r;
  logic                valid_res_r;
  logic signed [38:0]  epoch_r;
  logic [5:0]          corr_r;
  logic [5:0]          osec_r;
  logic [5:0]          omin_r;
  logic [4:0]          ohour_r;
  logic [4:0]          omday_r;
  logic [3:0]          omon_r;
  logic signed [14:0]  oyear_r;
  logic [2:0]          owday_r;
  logic [8:0]          oyday_r;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic [5:0]          cnt_inc;
  logic [3:0]          mon4;
  logic                leap_cur;
  logic [4:0]          len_cur;
  logic [3:0]          mon_prev;
  logic signed [14:0]  year_prev;
  logic [8:0]          r400_prev;
  logic signed [6:0]   q400_prev;
  logic [4:0]          len_prev;
  logic signed [15:0]  span;
  logic signed [18:0]  part;
  logic signed [22:0]  mul_a;
  logic signed [18:0]  mul_b;
  logic signed [41:0]  prod;
  logic [16:0]         tod;
  logic                load_ok;
  logic                load_bad;

  cfes_fdiv u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // calendar terms for the month roll and the final assembly
  always_comb begin
    cnt_inc  = (cnt_r == 6'd63) ? cnt_r : cnt_r + 6'd1;
    mon4     = mon_r[3:0];
    leap_cur = leap400(r400_r);
    len_cur  = month_days(mon4, leap_cur);

    if (mon4 == 4'd0) begin
      mon_prev  = 4'd11;
      year_prev = year_r - 15'sd1;
      r400_prev = (r400_r == 9'd0) ? 9'd399 : r400_r - 9'd1;
      q400_prev = (r400_r == 9'd0) ? q400_r - 7'sd1 : q400_r;
    end else begin
      mon_prev  = mon4 - 4'd1;
      year_prev = year_r;
      r400_prev = r400_r;
      q400_prev = q400_r;
    end
    len_prev = month_days(mon_prev, leap400(r400_prev));

    span = 16'(year_r) - EPOCH_SHIFT;
    part = 19'(yday_r) + 19'(cycle_days(r400_r)) - 19'(EPOCH_CYCLE_DAYS);

    if (state_r == S_MUL1) begin
      mul_a = 23'(q400_r) - 23'(EPOCH_CYCLE_Q);
      mul_b = 19'(CYCLE_DAYS);
    end else begin
      mul_a = day_r;
      mul_b = 19'(SECS_PER_DAY);
    end
    prod = mul_a * mul_b;

    tod = 17'(hour_r[4:0]) * 17'd3600 + 17'(min_r[5:0]) * 17'd60 + 17'(sec_r[5:0]);
  end

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    sec_nxt   = sec_r;
    min_nxt   = min_r;
    hour_nxt  = hour_r;
    mday_nxt  = mday_r;
    mon_nxt   = mon_r;
    year_nxt  = year_r;
    cnt_nxt   = cnt_r;
    r400_nxt  = r400_r;
    q400_nxt  = q400_r;
    yday_nxt  = yday_r;
    day_nxt   = day_r;
    wday_nxt  = wday_r;
    acc_nxt   = acc_r;
    load_ok   = 1'b0;
    load_bad  = 1'b0;
    div_req   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          sec_nxt   = in_second;
          min_nxt   = 17'(in_minute);
          hour_nxt  = 17'(in_hour);
          mday_nxt  = 17'(in_day_of_month);
          mon_nxt   = in_month;
          year_nxt  = 15'(in_year);
          cnt_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = S_SEC;
        end
      end
      S_SEC: begin
        // a second of 60 stays as a leap second
        div_req.num = 19'(sec_r);
        div_req.den = 9'd60;
        div_req.rcp = RCP_60;
        if (!pend_r) begin
          if ((sec_r < 16'sd0) || (sec_r > 16'sd60)) begin
            div_req.start = 1'b1;
            pend_nxt      = 1'b1;
            cnt_nxt       = cnt_inc;
          end else begin
            state_nxt = S_MIN;
          end
        end else if (div_rsp.done) begin
          sec_nxt   = $signed(16'(div_rsp.rem));
          min_nxt   = min_r + 17'(div_rsp.quo);
          pend_nxt  = 1'b0;
          state_nxt = S_MIN;
        end
      end
      S_MIN: begin
        div_req.num = 19'(min_r);
        div_req.den = 9'd60;
        div_req.rcp = RCP_60;
        if (!pend_r) begin
          if ((min_r < 17'sd0) || (min_r > 17'sd59)) begin
            div_req.start = 1'b1;
            pend_nxt      = 1'b1;
            cnt_nxt       = cnt_inc;
          end else begin
            state_nxt = S_HOUR;
          end
        end else if (div_rsp.done) begin
          min_nxt   = $signed(17'(div_rsp.rem));
          hour_nxt  = hour_r + 17'(div_rsp.quo);
          pend_nxt  = 1'b0;
          state_nxt = S_HOUR;
        end
      end
      S_HOUR: begin
        div_req.num = 19'(hour_r);
        div_req.den = 9'd24;
        div_req.rcp = RCP_24;
        if (!pend_r) begin
          if ((hour_r < 17'sd0) || (hour_r > 17'sd23)) begin
            div_req.start = 1'b1;
            pend_nxt      = 1'b1;
            cnt_nxt       = cnt_inc;
          end else begin
            state_nxt = S_MON;
          end
        end else if (div_rsp.done) begin
          hour_nxt  = $signed(17'(div_rsp.rem));
          mday_nxt  = mday_r + 17'(div_rsp.quo);
          pend_nxt  = 1'b0;
          state_nxt = S_MON;
        end
      end
      S_MON: begin
        div_req.num = 19'(mon_r);
        div_req.den = 9'd12;
        div_req.rcp = RCP_12;
        if (!pend_r) begin
          if ((mon_r < 13'sd0) || (mon_r > 13'sd11)) begin
            div_req.start = 1'b1;
            pend_nxt      = 1'b1;
            cnt_nxt       = cnt_inc;
          end else begin
            state_nxt = S_CHK;
          end
        end else if (div_rsp.done) begin
          mon_nxt   = $signed(13'(div_rsp.rem));
          year_nxt  = year_r + 15'(div_rsp.quo);
          pend_nxt  = 1'b0;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if ((mday_r < -DAY_LIM) || (mday_r > DAY_LIM)) begin
          load_bad  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          // calendar year split into 400 year cycles for the leap rule
          div_req.start = 1'b1;
          div_req.num   = 19'(year_r) + 19'(YEAR_BASE);
          div_req.den   = 9'd400;
          div_req.rcp   = RCP_400;
          state_nxt     = S_Y400;
        end
      end
      S_Y400: begin
        if (div_rsp.done) begin
          r400_nxt  = div_rsp.rem;
          q400_nxt  = 7'(div_rsp.quo);
          state_nxt = S_ROLL;
        end
      end
      S_ROLL: begin
        if (mday_r < 17'sd1) begin
          mon_nxt  = 13'(mon_prev);
          year_nxt = year_prev;
          r400_nxt = r400_prev;
          q400_nxt = q400_prev;
          mday_nxt = mday_r + $signed(17'(len_prev));
          cnt_nxt  = cnt_inc;
        end else if (mday_r > $signed(17'(len_cur))) begin
          mday_nxt = mday_r - $signed(17'(len_cur));
          cnt_nxt  = cnt_inc;
          if (mon4 == 4'd11) begin
            mon_nxt  = '0;
            year_nxt = year_r + 15'sd1;
            r400_nxt = (r400_r == 9'd399) ? 9'd0 : r400_r + 9'd1;
            q400_nxt = (r400_r == 9'd399) ? q400_r + 7'sd1 : q400_r;
          end else begin
            mon_nxt = mon_r + 13'sd1;
          end
        end else if ((span < -YEAR_LIM) || (span > YEAR_LIM)) begin
          load_bad  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        acc_nxt   = 40'(prod);
        yday_nxt  = 9'(mday_r - 17'sd1) + days_before(mon4, leap_cur);
        state_nxt = S_DAY;
      end
      S_DAY: begin
        // whole cycles are a multiple of 7 days, so the weekday needs only part
        day_nxt       = 23'(acc_r) + 23'(part);
        div_req.start = 1'b1;
        div_req.num   = part + 19'sd4;
        div_req.den   = 9'd7;
        div_req.rcp   = RCP_7;
        state_nxt     = S_WDAY;
      end
      S_WDAY: begin
        if (div_rsp.done) begin
          wday_nxt  = 3'(div_rsp.rem);
          state_nxt = S_MUL2;
        end
      end
      S_MUL2: begin
        acc_nxt   = 40'(prod);
        state_nxt = S_SUM;
      end
      S_SUM: begin
        acc_nxt   = acc_r + 40'(tod);
        load_ok   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pend_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pend_r   <= pend_nxt;
      strobe_r <= load_ok | load_bad;
    end
  end

  always_ff @(posedge clk) begin
    sec_r  <= sec_nxt;
    min_r  <= min_nxt;
    hour_r <= hour_nxt;
    mday_r <= mday_nxt;
    mon_r  <= mon_nxt;
    year_r <= year_nxt;
    cnt_r  <= cnt_nxt;
    r400_r <= r400_nxt;
    q400_r <= q400_nxt;
    yday_r <= yday_nxt;
    day_r  <= day_nxt;
    wday_r <= wday_nxt;
    acc_r  <= acc_nxt;
  end

  // result holding registers
  always_ff @(posedge clk) begin
    if (load_ok) begin
      valid_res_r <= 1'b1;
      epoch_r     <= 39'(acc_nxt);
      corr_r      <= cnt_r;
      osec_r      <= sec_r[5:0];
      omin_r      <= min_r[5:0];
      ohour_r     <= hour_r[4:0];
      omday_r     <= mday_r[4:0];
      omon_r      <= mon4;
      oyear_r     <= year_r;
      owday_r     <= wday_r;
      oyday_r     <= yday_r;
    end else if (load_bad) begin
      valid_res_r <= 1'b0;
      epoch_r     <= '0;
      corr_r      <= '0;
      osec_r      <= '0;
      omin_r      <= '0;
      ohour_r     <= '0;
      omday_r     <= '0;
      omon_r      <= '0;
      oyear_r     <= '0;
      owday_r     <= '0;
      oyday_r     <= '0;
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_strobe        = strobe_r;
  assign out_valid_res     = valid_res_r;
  assign out_epoch_seconds = epoch_r;
  assign out_corrections   = corr_r;
  assign out_second        = osec_r;
  assign out_minute        = omin_r;
  assign out_hour          = ohour_r;
  assign out_day_of_month  = omday_r;
  assign out_month         = omon_r;
  assign out_year          = oyear_r;
  assign out_weekday       = owday_r;
  assign out_day_of_year   = oyday_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy && $past(busy))
    else $error("result strobe outside the end of an item");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_valid_res |-> out_epoch_seconds == '0 && out_corrections == '0
      && out_day_of_month == '0 && out_year == '0)
    else $error("invalid result carries nonzero fields");

  a_ok_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_valid_res |-> out_second <= 6'd60 && out_minute <= 6'd59
      && out_hour <= 5'd23 && out_month <= 4'd11 && out_day_of_month >= 5'd1
      && out_weekday <= 3'd6 && out_day_of_year <= 9'd365)
    else $error("normalized field out of range");

endmodule

### bench/epoch_checker.sv
`timescale 1ns / 1ps
// result checker for the calendar fields to epoch seconds converter: watches both
// channels, predicts each result from the accepted item and compares field by field
// depends on cfes_pkg for the calendar limits and constants
module epoch_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic signed [15:0] in_second,
  input  logic signed [15:0] in_minute,
  input  logic signed [15:0] in_hour,
  input  logic signed [15:0] in_day_of_month,
  input  logic signed [12:0] in_month,
  input  logic signed [13:0] in_year,
  input  logic               out_strobe,
  input  logic               out_valid_res,
  input  logic signed [38:0] out_epoch_seconds,
  input  logic [5:0]         out_corrections,
  input  logic [5:0]         out_second,
  input  logic [5:0]         out_minute,
  input  logic [4:0]         out_hour,
  input  logic [4:0]         out_day_of_month,
  input  logic [3:0]         out_month,
  input  logic signed [14:0] out_year,
  input  logic [2:0]         out_weekday,
  input  logic [8:0]         out_day_of_year,
  output int                 errors,
  output int                 pending,
  output int                 checked,
  output int                 valid_seen
);
  import cfes_pkg::*;

  typedef struct packed {
    logic               valid;
    logic signed [38:0] secs;
    logic [5:0]         corr;
    logic [5:0]         sec;
    logic [5:0]         min;
    logic [4:0]         hour;
    logic [4:0]         mday;
    logic [3:0]         mon;
    logic signed [14:0] year;
    logic [2:0]         wday;
    logic [8:0]         yday;
  } stamp_t;

  localparam int MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  // keeps the day count arguments positive for every year in range
  localparam longint YEAR_SHIFT = 16000;

  stamp_t stamps_due [$];
  stamp_t want;
  int     bad;

  function automatic longint floor_div(input longint v, input longint m);
    longint q;
    q = v / m;
    if (v % m < 0) q--;
    return q;
  endfunction

  function automatic bit is_leap(input longint y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic longint days_in(input longint mon, input longint cal);
    return MONTH_LEN[mon] + ((mon == 1 && is_leap(cal)) ? 1 : 0);
  endfunction

  function automatic longint days_from_zero(input longint y);
    return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
  endfunction

  function automatic stamp_t to_epoch(input logic signed [15:0] i_sec,
                                      input logic signed [15:0] i_min,
                                      input logic signed [15:0] i_hour,
                                      input logic signed [15:0] i_mday,
                                      input logic signed [12:0] i_mon,
                                      input logic signed [13:0] i_year);
    stamp_t r;
    longint sec, min, hour, mday, mon, year, q, len, cal, yday, day, wday, secs;
    int cnt;
    r = '0;
    sec = i_sec;
    min = i_min;
    hour = i_hour;
    mday = i_mday;
    mon = i_mon;
    year = i_year;
    cnt = 0;
    // floor carries, second 60 stays as a leap second
    if (sec < 0 || sec > 60) begin
      q = floor_div(sec, 60);
      cnt++;
      sec -= q * 60;
      min += q;
    end
    if (min < 0 || min > 59) begin
      q = floor_div(min, 60);
      cnt++;
      min -= q * 60;
      hour += q;
    end
    if (hour < 0 || hour > 23) begin
      q = floor_div(hour, 24);
      cnt++;
      hour -= q * 24;
      mday += q;
    end
    if (mon < 0 || mon > 11) begin
      q = floor_div(mon, 12);
      cnt++;
      mon -= q * 12;
      year += q;
    end
    if (mday < -DAY_FIELD_LIMIT || mday > DAY_FIELD_LIMIT) return r;
    while (mday < 1) begin
      cnt++;
      mon--;
      if (mon < 0) begin
        mon += 12;
        year--;
      end
      mday += days_in(mon, YEAR_BASE + year);
    end
    while (mday > days_in(mon, YEAR_BASE + year)) begin
      len = days_in(mon, YEAR_BASE + year);
      cnt++;
      mon++;
      if (mon > 11) begin
        mon -= 12;
        year++;
      end
      mday -= len;
    end
    cal = YEAR_BASE + year;
    if (cal - EPOCH_YEAR < -YEAR_SPAN_LIMIT || cal - EPOCH_YEAR > YEAR_SPAN_LIMIT) return r;
    yday = mday - 1;
    for (int i = 0; i < mon; i++) yday += MONTH_LEN[i];
    if (mon > 1 && is_leap(cal)) yday++;
    day = yday + days_from_zero(cal + YEAR_SHIFT) - days_from_zero(EPOCH_YEAR + YEAR_SHIFT);
    wday = (day + 4) % 7;
    if (wday < 0) wday += 7;
    secs = sec + min * 60 + hour * 3600 + day * SECS_PER_DAY;
    r.valid = 1'b1;
    r.secs = secs[38:0];
    r.corr = (cnt > 63) ? 6'd63 : 6'(cnt);
    r.sec = sec[5:0];
    r.min = min[5:0];
    r.hour = hour[4:0];
    r.mday = mday[4:0];
    r.mon = mon[3:0];
    r.year = year[14:0];
    r.wday = wday[2:0];
    r.yday = yday[8:0];
    return r;
  endfunction

  function automatic int field_diff(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      errors <= 0;
      pending <= 0;
      checked <= 0;
      valid_seen <= 0;
    end else begin
      if (start && !busy)
        stamps_due.push_back(to_epoch(in_second, in_minute, in_hour, in_day_of_month,
                                      in_month, in_year));
      if (out_strobe) begin
        if (stamps_due.size() == 0) begin
          $display("%0t: result with no item outstanding", $time);
          errors <= errors + 1;
        end else begin
          want = stamps_due.pop_front();
          bad = field_diff("valid_res", want.valid, out_valid_res)
              + field_diff("epoch_seconds", want.secs, out_epoch_seconds)
              + field_diff("corrections", want.corr, out_corrections)
              + field_diff("second", want.sec, out_second)
              + field_diff("minute", want.min, out_minute)
              + field_diff("hour", want.hour, out_hour)
              + field_diff("day_of_month", want.mday, out_day_of_month)
              + field_diff("month", want.mon, out_month)
              + field_diff("year", want.year, out_year)
              + field_diff("weekday", want.wday, out_weekday)
              + field_diff("day_of_year", want.yday, out_day_of_year);
          errors <= errors + bad;
          checked <= checked + 1;
          if (want.valid) valid_seen <= valid_seen + 1;
        end
      end
      pending <= stamps_due.size();
    end
  end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// bench top for calendar_fields_to_epoch_seconds: drives directed and random items
// and gives the verdict; checking is done by epoch_checker, types from cfes_pkg
module tb;

  localparam int DIRECTED_ITEMS = 24;
  localparam int RANDOM_ITEMS   = 1926;
  localparam int STALL_LIMIT    = 2000;
  localparam int TAIL_CYCLES    = 150;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [15:0] in_second;
  logic signed [15:0] in_minute;
  logic signed [15:0] in_hour;
  logic signed [15:0] in_day_of_month;
  logic signed [12:0] in_month;
  logic signed [13:0] in_year;
  logic               out_strobe;
  logic               out_valid_res;
  logic signed [38:0] out_epoch_seconds;
  logic [5:0]         out_corrections;
  logic [5:0]         out_second;
  logic [5:0]         out_minute;
  logic [4:0]         out_hour;
  logic [4:0]         out_day_of_month;
  logic [3:0]         out_month;
  logic signed [14:0] out_year;
  logic [2:0]         out_weekday;
  logic [8:0]         out_day_of_year;

  int errors, pending, checked, valid_seen;
  int items_sent;
  int idle_cycles;
  int n, pick, gap, s, m, h, d, mo, y;
  bit burst;

  calendar_fields_to_epoch_seconds u_top (.*);

  epoch_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog: cycles with neither an item taken nor a result seen
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic drive_item(input int sec, input int min, input int hour, input int mday,
                            input int mon, input int year, input int wait_cycles);
    if (wait_cycles > 0) begin
      start = 1'b0;
      repeat (wait_cycles) @(negedge clk);
    end
    start = 1'b1;
    in_second = 16'(sec);
    in_minute = 16'(min);
    in_hour = 16'(hour);
    in_day_of_month = 16'(mday);
    in_month = 13'(mon);
    in_year = 14'(year);
    do @(posedge clk); while (busy);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic int srange(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // year minus 1900: near the epoch, on the span limits, or anywhere valid
  function automatic int pick_year();
    case ($urandom_range(0, 3))
      0:       return srange(60, 80);
      1:       return $urandom_range(0, 1) ? srange(-4931, -4930) : srange(5070, 5071);
      default: return srange(-4930, 5070);
    endcase
  endfunction

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_second = '0;
    in_minute = '0;
    in_hour = '0;
    in_day_of_month = '0;
    in_month = '0;
    in_year = '0;
    items_sent = 0;
    burst = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed: epoch, epoch minus one, leap second, leap rules, field extremes, limits
    drive_item(0, 0, 0, 1, 0, 70, 0);
    drive_item(59, 59, 23, 31, 11, 69, 0);
    drive_item(60, 59, 23, 31, 11, 98, 3);
    drive_item(0, 0, 0, 29, 1, 100, 0);
    drive_item(0, 0, 0, 29, 1, 0, 0);
    drive_item(0, 0, 0, 29, 1, 200, 5);
    drive_item(0, 0, 0, 0, 0, 0, 0);
    drive_item(-32768, -32768, -32768, -32768, -4096, -8192, 0);
    drive_item(32767, 32767, 32767, 32767, 4095, 8191, 1);
    drive_item(-1, 0, 0, 1, 0, 70, 0);
    drive_item(61, 60, 24, 1, 12, 70, 0);
    drive_item(0, -1, -1, 1, -1, 70, 7);
    drive_item(12, 34, 5, 1000, 0, 70, 0);
    drive_item(12, 34, 5, -1000, 0, 70, 0);
    drive_item(0, 0, 0, 1001, 0, 70, 2);
    drive_item(0, 0, 0, -1001, 0, 70, 0);
    drive_item(0, 0, 24000, 1, 0, 70, 0);
    drive_item(0, 0, 0, 1, 0, 5070, 0);
    drive_item(0, 0, 0, 1, 0, 5071, 19);
    drive_item(0, 0, 0, 1, 0, -4930, 0);
    drive_item(0, 0, 0, 1, 0, -4931, 0);
    drive_item(0, 0, 0, 32, 11, 5070, 0);
    drive_item(59, 59, 23, 0, 0, -4930, 4);
    drive_item(-3600, 1440, -48, 400, 35, 120, 0);

    // let the directed results drain before the random part
    start = 1'b0;
    while (pending != 0) @(negedge clk);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) burst = ($urandom_range(0, 2) == 0);
      if (n == RANDOM_ITEMS / 2) begin
        start = 1'b0;
        while (pending != 0) @(negedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        // well formed fields, day may still run past the month end
        s = srange(0, 60);
        m = srange(0, 59);
        h = srange(0, 23);
        d = srange(1, 31);
        mo = srange(0, 11);
        y = pick_year();
      end else if (pick < 85) begin
        s = srange(-200, 200);
        m = srange(-200, 200);
        h = srange(-100, 100);
        d = srange(-100, 100);
        mo = srange(-40, 40);
        y = pick_year();
      end else begin
        s = $urandom();
        m = $urandom();
        h = $urandom();
        d = $urandom();
        mo = $urandom();
        y = $urandom();
      end
      gap = burst ? 0 : srange(0, 19);
      drive_item(s, m, h, d, mo, y, gap);
    end
    start = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d items (%0d directed), %0d results checked, %0d of them valid",
             items_sent, DIRECTED_ITEMS, checked, valid_seen);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/cfes_pkg.sv
rtl/cfes_fdiv.sv
rtl/calendar_fields_to_epoch_seconds.sv
bench/epoch_checker.sv
bench/tb.sv
